// ===== sv/vphs_pkg.sv =====
`timescale 1ns / 1ps

package vphs_pkg;

    // Field widths of the channels
    localparam int NODE_W     = 64;
    localparam int LEVEL_IN_W = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 10;
    localparam int TOTAL_W    = 10;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF      = 1024;
    localparam int LEVEL_BITS_DEF = 16;

    // Hash finalizer constants
    localparam logic [NODE_W-1:0] MIX_ADD = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [NODE_W-1:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [NODE_W-1:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    // Slot tag generation width; tag zero means never written this pass
    localparam int EPOCH_W = 4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_READ,
        B_CHECK
    } back_state_t;

endpackage

// ===== sv/vphs_in_if.sv =====
`timescale 1ns / 1ps

interface vphs_in_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic [vphs_pkg::NODE_W-1:0]      node_key;
    logic [vphs_pkg::LEVEL_IN_W-1:0]  level_key;

    modport source (output valid, command, node_key, level_key, input ready);
    modport sink   (input valid, command, node_key, level_key, output ready);
endinterface

// ===== sv/vphs_out_if.sv =====
`timescale 1ns / 1ps

interface vphs_out_if;
    logic                             valid;
    logic                             ready;
    logic [vphs_pkg::STATUS_W-1:0]    status;
    logic [vphs_pkg::SLOT_OUT_W-1:0]  slot_index;
    logic [vphs_pkg::TOTAL_W-1:0]     entry_total;

    modport source (output valid, status, slot_index, entry_total, input ready);
    modport sink   (input valid, status, slot_index, entry_total, output ready);
endinterface

// ===== sv/visited_pair_hash_set_top.sv =====
`timescale 1ns / 1ps
// An insert passes the front (hash, modulo), the queue and the probe loop, which reads
//   one further slot per collision; a clear goes from the queue straight to the result.
// The front takes no new item before the last is in the queue; an insert runs 8 steps
//   on the shared 32x32 multiplier, then a modulo step unless SLOTS is a power of 2.
// Reset: control clears at once, then a tag sweep of all slots holds req.ready low;
//   the same sweep follows every 15th clear, when the slot epoch wraps.

module visited_pair_hash_set_top #(
    parameter int SLOTS      = vphs_pkg::SLOTS_DEF,
    parameter int LEVEL_BITS = vphs_pkg::LEVEL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vphs_in_if.sink     req,
    vphs_out_if.source  rsp
);

    // Only the low LEVEL_BITS bits of level_key take part in hash and compare.
    localparam int LVL_W  = (LEVEL_BITS < vphs_pkg::LEVEL_IN_W) ?
                            LEVEL_BITS : vphs_pkg::LEVEL_IN_W;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int Q_W    = 1 + vphs_pkg::NODE_W + LVL_W + SLOT_W;

    // front -> queue
    logic                        f_push_valid;
    logic                        f_push_ready;
    logic                        f_cmd;
    logic [vphs_pkg::NODE_W-1:0] f_node;
    logic [LVL_W-1:0]            f_level;
    logic [SLOT_W-1:0]           f_home;
    logic [Q_W-1:0]              q_push_data;

    // queue -> back
    logic                        q_pop_valid;
    logic                        q_pop_ready;
    logic [Q_W-1:0]              q_pop_data;

    // back holds off new transfers during a tag sweep
    logic                        sweeping;

    // Front: takes each transfer, hashes inserts, computes the home slot.
    vphs_front #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .hold       (sweeping),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_cmd   (f_cmd),
        .push_node  (f_node),
        .push_level (f_level),
        .push_home  (f_home)
    );

    assign q_push_data = {f_cmd, f_node, f_level, f_home};

    // Short queue so hashing of the next item overlaps the probe loop.
    vphs_queue #(
        .DATA_W (Q_W),
        .DEPTH  (vphs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back: linear probing over the slot memories, one probe per cycle,
    // result held in an output register so the next item can start.
    vphs_back #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_data[Q_W-1]),
        .pop_node   (q_pop_data[Q_W-2 -: vphs_pkg::NODE_W]),
        .pop_level  (q_pop_data[SLOT_W +: LVL_W]),
        .pop_home   (q_pop_data[SLOT_W-1:0]),
        .rsp        (rsp),
        .sweeping   (sweeping)
    );

endmodule

// ===== sv/vphs_front.sv =====
`timescale 1ns / 1ps

// Accepts items, hashes insert keys with one shared 32x32 multiplier,
// reduces the hash to a home slot and hands the item to the queue.
module vphs_front #(
    parameter int SLOTS      = vphs_pkg::SLOTS_DEF,
    parameter int LEVEL_BITS = vphs_pkg::LEVEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    vphs_in_if.sink                                req,
    input  logic                                   hold,
    output logic                                   push_valid,
    input  logic                                   push_ready,
    output logic                                   push_cmd,
    output logic [vphs_pkg::NODE_W-1:0]            push_node,
    output logic [((LEVEL_BITS < vphs_pkg::LEVEL_IN_W) ?
                   LEVEL_BITS : vphs_pkg::LEVEL_IN_W)-1:0] push_level,
    output logic [$clog2(SLOTS)-1:0]               push_home
);

    localparam int LVL_W    = (LEVEL_BITS < vphs_pkg::LEVEL_IN_W) ?
                              LEVEL_BITS : vphs_pkg::LEVEL_IN_W;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int NW       = vphs_pkg::NODE_W;
    localparam int HW       = NW / 2;
    localparam int DIG_W    = 16;
    localparam int DIG_N    = NW / DIG_W;
    localparam int BIT_CW   = $clog2(2 * DIG_N);
    localparam int Q_SH     = 32 + SLOT_W;
    localparam bit IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
    // floor(2^(32+SLOT_W) / SLOTS); the quotient estimate is low by at most one
    localparam logic [32:0] RECIP = 33'((64'd1 << Q_SH) / 64'(SLOTS));

    vphs_pkg::front_state_t state_reg, state_next;

    logic              cmd_reg, cmd_next;
    logic [NW-1:0]     node_reg, node_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [1:0]        step_reg, step_next;
    logic              pass_reg, pass_next;
    logic [NW-1:0]     plo_reg, plo_next;
    logic [HW-1:0]     cross_reg, cross_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [BIT_CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [31:0]       q_reg, q_next;

    logic [HW-1:0]     mul_a, mul_b;
    logic [NW-1:0]     mul_p;
    logic [NW-1:0]     mul_k;
    logic [NW-1:0]     prod;
    logic [NW-1:0]     mix_in;
    logic [31:0]       rem_num;
    logic [64:0]       recip_p;
    logic [31:0]       rem_raw;

    assign mul_p = NW'(mul_a) * NW'(mul_b);
    assign mul_k = pass_reg ? vphs_pkg::MIX_MUL2 : vphs_pkg::MIX_MUL1;
    assign prod  = plo_reg + {cross_reg, HW'(0)};
    assign mix_in = req.node_key ^ (NW'(req.level_key[LVL_W-1:0]) + vphs_pkg::MIX_ADD);

    // modulo by a constant: partial remainder times 2^16 plus the next hash digit
    assign rem_num = {DIG_W'(home_reg), v_reg[NW-1 -: DIG_W]};
    assign recip_p = 65'(rem_num) * 65'(RECIP);
    assign rem_raw = rem_num - q_reg * 32'(SLOTS);

    assign req.ready  = (state_reg == vphs_pkg::F_IDLE) && !hold;
    assign push_valid = (state_reg == vphs_pkg::F_PUSH);
    assign push_cmd   = cmd_reg;
    assign push_node  = node_reg;
    assign push_level = level_reg;
    assign push_home  = home_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        node_next    = node_reg;
        level_next   = level_reg;
        v_next       = v_reg;
        step_next    = step_reg;
        pass_next    = pass_reg;
        plo_next     = plo_reg;
        cross_next   = cross_reg;
        home_next    = home_reg;
        bit_cnt_next = bit_cnt_reg;
        q_next       = q_reg;
        mul_a        = v_reg[HW-1:0];
        mul_b        = mul_k[HW-1:0];

        case (state_reg)
            vphs_pkg::F_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cmd_next   = req.command;
                    node_next  = req.node_key;
                    level_next = req.level_key[LVL_W-1:0];
                    v_next     = mix_in ^ (mix_in >> vphs_pkg::MIX_SH0);
                    step_next  = 2'd0;
                    pass_next  = 1'b0;
                    home_next  = '0;
                    state_next = req.command ? vphs_pkg::F_PUSH : vphs_pkg::F_MUL;
                end
            end
            vphs_pkg::F_MUL:
            begin
                // 64x64 low product from three 32x32 partial products
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd0:
                    begin
                        plo_next = mul_p;
                    end
                    2'd1:
                    begin
                        mul_b      = mul_k[NW-1:HW];
                        cross_next = mul_p[HW-1:0];
                    end
                    2'd2:
                    begin
                        mul_a      = v_reg[NW-1:HW];
                        cross_next = cross_reg + mul_p[HW-1:0];
                    end
                    default:
                    begin
                        if (!pass_reg)
                        begin
                            v_next    = prod ^ (prod >> vphs_pkg::MIX_SH1);
                            pass_next = 1'b1;
                        end
                        else
                        begin
                            v_next       = prod ^ (prod >> vphs_pkg::MIX_SH2);
                            home_next    = '0;
                            bit_cnt_next = '0;
                            state_next   = vphs_pkg::F_MOD;
                        end
                    end
                endcase
            end
            vphs_pkg::F_MOD:
            begin
                if (IS_POW2)
                begin
                    home_next  = v_reg[SLOT_W-1:0];
                    state_next = vphs_pkg::F_PUSH;
                end
                else
                begin
                    // one 16-bit hash digit per pass, MSB first: quotient estimate, then remainder
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (!bit_cnt_reg[0])
                    begin
                        q_next = 32'(recip_p >> Q_SH);
                    end
                    else
                    begin
                        if (rem_raw >= 32'(SLOTS))
                        begin
                            home_next = SLOT_W'(rem_raw - 32'(SLOTS));
                        end
                        else
                        begin
                            home_next = SLOT_W'(rem_raw);
                        end
                        v_next = v_reg << DIG_W;
                        if (bit_cnt_reg == BIT_CW'(2 * DIG_N - 1))
                        begin
                            state_next = vphs_pkg::F_PUSH;
                        end
                    end
                end
            end
            vphs_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = vphs_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = vphs_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vphs_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        node_reg    <= node_next;
        level_reg   <= level_next;
        v_reg       <= v_next;
        step_reg    <= step_next;
        pass_reg    <= pass_next;
        plo_reg     <= plo_next;
        cross_reg   <= cross_next;
        home_reg    <= home_next;
        bit_cnt_reg <= bit_cnt_next;
        q_reg       <= q_next;
    end

endmodule

// ===== sv/vphs_queue.sv =====
`timescale 1ns / 1ps

// Small FIFO between the hash front and the probe back.
module vphs_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = vphs_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/vphs_back.sv =====
`timescale 1ns / 1ps

// Probe engine: slot memories, linear probe loop, occupancy count and
// the registered result stage.
module vphs_back #(
    parameter int SLOTS      = vphs_pkg::SLOTS_DEF,
    parameter int LEVEL_BITS = vphs_pkg::LEVEL_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pop_valid,
    output logic                                   pop_ready,
    input  logic                                   pop_cmd,
    input  logic [vphs_pkg::NODE_W-1:0]            pop_node,
    input  logic [((LEVEL_BITS < vphs_pkg::LEVEL_IN_W) ?
                   LEVEL_BITS : vphs_pkg::LEVEL_IN_W)-1:0] pop_level,
    input  logic [$clog2(SLOTS)-1:0]               pop_home,
    vphs_out_if.source                             rsp,
    output logic                                   sweeping
);

    localparam int LVL_W  = (LEVEL_BITS < vphs_pkg::LEVEL_IN_W) ?
                            LEVEL_BITS : vphs_pkg::LEVEL_IN_W;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS / 2 + 1);
    localparam int NW     = vphs_pkg::NODE_W;
    localparam int EW     = vphs_pkg::EPOCH_W;
    localparam logic [EW-1:0]     EPOCH_MAX = '1;
    localparam logic [CNT_W-1:0]  HALF      = CNT_W'(SLOTS / 2);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // slot memories; tag equal to the current epoch marks an occupied slot
    logic [NW-1:0]    key_node_mem  [SLOTS];
    logic [LVL_W-1:0] key_level_mem [SLOTS];
    logic [EW-1:0]    tag_mem       [SLOTS];

    logic [NW-1:0]    rd_node_reg;
    logic [LVL_W-1:0] rd_level_reg;
    logic [EW-1:0]    rd_tag_reg;

    vphs_pkg::back_state_t state_reg, state_next;

    logic [EW-1:0]     epoch_reg, epoch_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [NW-1:0]     cur_node_reg, cur_node_next;
    logic [LVL_W-1:0]  cur_level_reg, cur_level_next;

    logic                           out_valid_reg, out_valid_next;
    vphs_pkg::status_t              out_status_reg, out_status_next;
    logic [vphs_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [vphs_pkg::TOTAL_W-1:0]   out_total_reg, out_total_next;

    logic              res_free;
    logic              emit;
    vphs_pkg::status_t emit_status;
    logic [SLOT_W-1:0] emit_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] slot_inc;
    logic              key_we;
    logic              tag_we;
    logic [EW-1:0]     tag_wd;
    logic              occupied;
    logic              key_match;

    assign res_free  = !out_valid_reg || rsp.ready;
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign occupied  = (rd_tag_reg == epoch_reg);
    assign key_match = (rd_node_reg == cur_node_reg) && (rd_level_reg == cur_level_reg);
    assign sweeping  = (state_reg == vphs_pkg::B_SWEEP);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.slot_index  = out_slot_reg;
    assign rsp.entry_total = out_total_reg;

    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        cur_node_next  = cur_node_reg;
        cur_level_next = cur_level_reg;
        pop_ready      = 1'b0;
        rd_addr        = slot_reg;
        key_we         = 1'b0;
        tag_we         = 1'b0;
        tag_wd         = epoch_reg;
        emit           = 1'b0;
        emit_status    = vphs_pkg::ST_NEW;
        emit_slot      = '0;

        case (state_reg)
            vphs_pkg::B_SWEEP:
            begin
                tag_we    = 1'b1;
                tag_wd    = '0;
                slot_next = slot_inc;
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = vphs_pkg::B_IDLE;
                end
            end
            vphs_pkg::B_IDLE:
            begin
                if (pop_valid && res_free)
                begin
                    pop_ready = 1'b1;
                    if (pop_cmd)
                    begin
                        count_next  = '0;
                        emit        = 1'b1;
                        emit_status = vphs_pkg::ST_CLEARED;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            epoch_next = EW'(1);
                            slot_next  = '0;
                            state_next = vphs_pkg::B_SWEEP;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cur_node_next  = pop_node;
                        cur_level_next = pop_level;
                        slot_next      = pop_home;
                        state_next     = vphs_pkg::B_READ;
                    end
                end
            end
            vphs_pkg::B_READ:
            begin
                state_next = vphs_pkg::B_CHECK;
            end
            vphs_pkg::B_CHECK:
            begin
                if (!occupied)
                begin
                    if (res_free)
                    begin
                        emit       = 1'b1;
                        state_next = vphs_pkg::B_IDLE;
                        if (count_reg >= HALF)
                        begin
                            emit_status = vphs_pkg::ST_FULL;
                        end
                        else
                        begin
                            key_we      = 1'b1;
                            tag_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            emit_status = vphs_pkg::ST_NEW;
                            emit_slot   = slot_reg;
                        end
                    end
                end
                else if (key_match)
                begin
                    if (res_free)
                    begin
                        emit        = 1'b1;
                        emit_status = vphs_pkg::ST_PRESENT;
                        emit_slot   = slot_reg;
                        state_next  = vphs_pkg::B_IDLE;
                    end
                end
                else
                begin
                    // collision: read the next slot, one probe per cycle
                    slot_next = slot_inc;
                    rd_addr   = slot_inc;
                end
            end
            default:
            begin
                state_next = vphs_pkg::B_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_total_next  = out_total_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_slot_next   = vphs_pkg::SLOT_OUT_W'(emit_slot);
            out_total_next  = vphs_pkg::TOTAL_W'(count_next);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vphs_pkg::B_SWEEP;
            epoch_reg     <= EW'(1);
            slot_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_node_reg   <= cur_node_next;
        cur_level_reg  <= cur_level_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_total_reg  <= out_total_next;
    end

    always_ff @(posedge clk)
    begin
        rd_node_reg  <= key_node_mem[rd_addr];
        rd_level_reg <= key_level_mem[rd_addr];
        if (key_we)
        begin
            key_node_mem[slot_reg]  <= cur_node_reg;
            key_level_mem[slot_reg] <= cur_level_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= tag_mem[rd_addr];
        if (tag_we)
        begin
            tag_mem[slot_reg] <= tag_wd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= HALF)
        else $error("stored count above half capacity");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch collides with the swept tag value");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_status == vphs_pkg::ST_CLEARED) |=> (count_reg == '0))
        else $error("clear left entries counted");

    a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_status == vphs_pkg::ST_NEW) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("new entry not counted");
`endif

endmodule

// ===== tb/vphs_tb_pkg.sv =====
`timescale 1ns / 1ps

package vphs_tb_pkg;

    // Request command codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_CLEAR  = 1'b1
    } command_t;

endpackage

// ===== tb/vphs_visit_checker.sv =====
`timescale 1ns / 1ps

module vphs_visit_checker #(
    parameter int SLOTS      = vphs_pkg::SLOTS_DEF,
    parameter int LEVEL_BITS = vphs_pkg::LEVEL_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    vphs_in_if   req,
    vphs_out_if  rsp,
    output int   mismatches,
    output int   pending
);
    import vphs_pkg::*;
    import vphs_tb_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [TOTAL_W-1:0]     total;
    } visit_reply_t;

    localparam logic [63:0] LEVEL_KEEP =
        (LEVEL_BITS >= 64) ? {64{1'b1}} : ((64'd1 << LEVEL_BITS) - 64'd1);

    // Shadow copy of the table
    logic [NODE_W-1:0]     node_tab  [SLOTS];
    logic [LEVEL_IN_W-1:0] level_tab [SLOTS];
    bit                    used_tab  [SLOTS];
    int unsigned           stored;
    visit_reply_t          reply_q[$];

    function automatic logic [NODE_W-1:0] pair_hash(input logic [NODE_W-1:0] node,
                                                    input logic [NODE_W-1:0] level);
        logic [NODE_W-1:0] v;
        v = node ^ (level + MIX_ADD);
        v = v ^ (v >> MIX_SH0);
        v = v * MIX_MUL1;
        v = v ^ (v >> MIX_SH1);
        v = v * MIX_MUL2;
        return v ^ (v >> MIX_SH2);
    endfunction

    // Applies one request to the shadow table and returns the reply it should get.
    function automatic visit_reply_t visit_pair(input command_t cmd,
                                                input logic [NODE_W-1:0] node,
                                                input logic [LEVEL_IN_W-1:0] level_raw);
        logic [LEVEL_IN_W-1:0] level;
        logic [NODE_W-1:0]     slots_wide;
        logic [NODE_W-1:0]     home;
        int unsigned           slot;
        int unsigned           probes;
        visit_reply_t          reply;
        level      = level_raw & LEVEL_KEEP[LEVEL_IN_W-1:0];
        slots_wide = NODE_W'(SLOTS);
        reply.slot = '0;
        if (cmd == CMD_CLEAR)
        begin
            // stored keys stay, only occupancy drops
            foreach (used_tab[i]) used_tab[i] = 1'b0;
            stored       = 0;
            reply.status = ST_CLEARED;
        end
        else
        begin
            home   = pair_hash(node, {{(NODE_W-LEVEL_IN_W){1'b0}}, level}) % slots_wide;
            slot   = home[31:0];
            probes = 0;
            while (probes < SLOTS && used_tab[slot]
                   && !(node_tab[slot] == node && level_tab[slot] == level))
            begin
                slot = (slot + 1) % SLOTS;
                probes++;
            end
            if (probes < SLOTS && used_tab[slot])
            begin
                reply.status = ST_PRESENT;
                reply.slot   = slot[SLOT_OUT_W-1:0];
            end
            else if (stored >= SLOTS / 2 || probes >= SLOTS)
            begin
                reply.status = ST_FULL;
            end
            else
            begin
                node_tab[slot]  = node;
                level_tab[slot] = level;
                used_tab[slot]  = 1'b1;
                stored++;
                reply.status = ST_NEW;
                reply.slot   = slot[SLOT_OUT_W-1:0];
            end
        end
        reply.total = stored[TOTAL_W-1:0];
        return reply;
    endfunction

    always @(posedge clk)
    begin : watch
        visit_reply_t want;
        int           bad;
        if (!rst_n)
        begin
            foreach (used_tab[i]) used_tab[i] = 1'b0;
            stored = 0;
            reply_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            // result side first: a request taken this edge cannot answer this edge
            if (rsp.valid && rsp.ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected result: status %0d slot_index %0d entry_total %0d",
                           rsp.status, rsp.slot_index, rsp.entry_total);
                    bad = 1;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        bad++;
                    end
                    if (rsp.slot_index !== want.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot, rsp.slot_index);
                        bad++;
                    end
                    if (rsp.entry_total !== want.total)
                    begin
                        $error("entry_total: expected %0d, actual %0d",
                               want.total, rsp.entry_total);
                        bad++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                reply_q.push_back(visit_pair(command_t'(req.command),
                                             req.node_key, req.level_key));
            end
            mismatches <= mismatches + bad;
            pending    <= reply_q.size();
        end
    end

endmodule

// ===== tb/visited_pair_hash_set_top_tb.sv =====
`timescale 1ns / 1ps

module visited_pair_hash_set_top_tb;
    import vphs_pkg::*;
    import vphs_tb_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int LEVEL_BITS     = LEVEL_BITS_DEF;
    localparam int RX_HOLD_CYCLES = 400;   // long result back-pressure stretch
    localparam int KEY_POOL_MAX   = 64;    // recent keys kept for repeats
    localparam int TAIL_CYCLES    = 64;    // quiet time after the last result

    typedef struct packed {
        logic [NODE_W-1:0]     node;
        logic [LEVEL_IN_W-1:0] level;
    } key_pair_t;

    logic clk;
    logic rst_n;

    vphs_in_if  req_ch ();
    vphs_out_if rsp_ch ();

    int   mismatches;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic rx_hold_req;

    key_pair_t key_pool[$];    // up to KEY_POOL_MAX recent keys, survive clears
    key_pair_t fill_keys[$];   // keys stored during the fill pass

    visited_pair_hash_set_top #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    vphs_visit_checker #(
        .SLOTS      (SLOTS),
        .LEVEL_BITS (LEVEL_BITS)
    ) visit_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result sink: random stalls at rx_idle_pct, plus one long hold-off on request.
    // The hold is counted here so the sender keeps pushing while the block backs up.
    initial
    begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req === 1'b1 && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One transfer on the request channel. Called at a rising edge; returns at the
    // edge where the transfer happened, valid left high for back-to-back items.
    task automatic send_item(input command_t cmd, input logic [NODE_W-1:0] node,
                             input logic [LEVEL_IN_W-1:0] level);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.node_key  <= node;
        req_ch.level_key <= level;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Sender goes quiet until every outstanding result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic key_pair_t fresh_key();
        key_pair_t k;
        k.node  = {$urandom, $urandom};
        k.level = LEVEL_IN_W'($urandom);
        // small ranges make accidental repeats and near misses likely
        case ($urandom_range(5))
            0: k.level = '0;
            1: k.level = '1;
            2: k.level = LEVEL_IN_W'($urandom_range(7));
            3: k.node  = NODE_W'($urandom_range(15));
            default: ;
        endcase
        return k;
    endfunction

    function automatic void remember_key(input key_pair_t k);
        key_pool.push_back(k);
        if (key_pool.size() > KEY_POOL_MAX)
            void'(key_pool.pop_front());
    endfunction

    // Mixed traffic: clears, repeats of known keys (hits, or misses after a clear),
    // single-bit near misses, and fresh keys.
    task automatic send_random(input int clear_pct);
        int        roll;
        key_pair_t k;
        roll = $urandom_range(99);
        if (roll < clear_pct)
            send_item(CMD_CLEAR, {$urandom, $urandom}, LEVEL_IN_W'($urandom));
        else
        begin
            if (roll < 55 && key_pool.size() > 0)
            begin
                k = key_pool[$urandom_range(key_pool.size() - 1)];
                case ($urandom_range(5))
                    0: k.level = k.level ^ (LEVEL_IN_W'(1) << $urandom_range(LEVEL_IN_W - 1));
                    1: k.node  = k.node ^ (NODE_W'(1) << $urandom_range(NODE_W - 1));
                    default: ;
                endcase
            end
            else
            begin
                k = fresh_key();
                remember_key(k);
            end
            send_item(CMD_INSERT, k.node, k.level);
        end
    endtask

    initial
    begin : stimulus
        key_pair_t k;
        int        n;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_INSERT;
        req_ch.node_key  <= '0;
        req_ch.level_key <= '0;
        rx_hold_req      <= 1'b0;
        rx_idle_pct      <= 66;
        tx_idle_pct       = 7;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, hit after insert, level-only differences,
        // clear then reinsert of stale keys, clear of an empty table.
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_INSERT, '1, '0);
        send_item(CMD_INSERT, '0, '1);
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_INSERT, 64'd5, 16'd1);
        send_item(CMD_INSERT, 64'd5, 16'd2);
        send_item(CMD_INSERT, 64'd5, 16'd1);
        send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 16'h8000);
        send_item(CMD_CLEAR, '1, '1);
        send_item(CMD_INSERT, '0, '0);
        send_item(CMD_INSERT, '1, '1);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_INSERT, '1, '0);
        send_item(CMD_INSERT, '1, '0);

        // Phase 1: sender mostly busy, sink stalls a lot. One long sink hold-off
        // in the middle so the request side backs up and stalls.
        wait_drained();
        for (n = 0; n < 45; n++)
        begin
            if (n == 10)
                rx_hold_req <= 1'b1;
            if (n == 35)
                rx_hold_req <= 1'b0;
            send_random(8);
        end

        // Phase 2: fill to half of SLOTS, so probes get long and the table hits
        // its limit. Then new keys (refused), stored keys (still found with their
        // slot), a clear of the full table and a reinsert.
        wait_drained();
        tx_idle_pct  = 66;
        rx_idle_pct <= 7;
        send_item(CMD_CLEAR, {$urandom, $urandom}, LEVEL_IN_W'($urandom));
        fill_keys.delete();
        for (n = 0; n < SLOTS / 2; n++)
        begin
            k.node  = {$urandom, $urandom};
            k.level = LEVEL_IN_W'($urandom);
            send_item(CMD_INSERT, k.node, k.level);
            fill_keys.push_back(k);
            if (n % 16 == 15)
            begin
                remember_key(k);
                k = fill_keys[$urandom_range(fill_keys.size() - 1)];
                send_item(CMD_INSERT, k.node, k.level);
            end
        end
        for (n = 0; n < 8; n++)
        begin
            send_item(CMD_INSERT, {$urandom, $urandom}, LEVEL_IN_W'($urandom));
            k = fill_keys[$urandom_range(fill_keys.size() - 1)];
            send_item(CMD_INSERT, k.node, k.level);
        end
        k = fill_keys[0];
        send_item(CMD_INSERT, k.node, ~k.level);
        send_item(CMD_CLEAR, '0, '0);
        send_item(CMD_INSERT, k.node, k.level);

        // Phase 3: no idling on either side. A run of clears interleaved with
        // repeats pushes the block through its clear-generation wrap.
        wait_drained();
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        for (n = 0; n < 16; n++)
        begin
            send_item(CMD_CLEAR, {$urandom, $urandom}, LEVEL_IN_W'($urandom));
            send_random(0);
        end
        for (n = 0; n < 30; n++)
            send_random(12);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
